FILE: design/rgbe_pkg.sv
package rgbe_pkg;

  localparam int MAX_LINE_WIDTH = 4096;
  localparam int STORE_DEPTH    = 4 * MAX_LINE_WIDTH;
  localparam int STORE_AW       = $clog2(STORE_DEPTH);
  localparam int FULL_AW        = 18;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER = 3'd1;
  localparam logic [2:0] ST_WIDTH      = 3'd2;
  localparam logic [2:0] ST_ZERO_COUNT = 3'd3;
  localparam logic [2:0] ST_OVERFLOW   = 3'd4;
  localparam logic [2:0] ST_NO_LINE    = 3'd5;
  localparam logic [2:0] ST_PENDING    = 3'd6;
  localparam logic [2:0] ST_HALTED     = 3'd7;

  // opcodes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // register indexes
  localparam logic CFG_LINE_WIDTH   = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_WHI, PH_WLO, PH_COUNT, PH_RUNVAL, PH_LIT, PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE, S_RUN, S_RD, S_CV, S_EMIT
  } state_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        pixel_valid;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic        line_complete;
    logic        last_in_line;
    logic        last_in_image;
  } out_t;

endpackage

FILE: design/rgbe_ram.sv
module rgbe_ram #(
  parameter int Width = 8,
  parameter int Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: design/rgbe_flt.sv
module rgbe_flt import rgbe_pkg::*; (
  input  logic [7:0]  mant_i,
  input  logic [7:0]  exp_i,
  output logic [31:0] bits_o
);

  logic [2:0]  msb;
  logic [8:0]  sum;
  logic [4:0]  sub_sh;
  logic [31:0] norm;
  logic [31:0] subn;

  // leading one of the mantissa byte
  always_comb begin
    msb = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (mant_i[i]) msb = 3'(i);
    end
  end

  assign sum    = 9'(msb) + 9'(exp_i);
  assign sub_sh = 5'(exp_i[3:0]) + 5'd13;
  assign norm   = {24'd0, mant_i} << (5'd23 - 5'(msb));
  assign subn   = {24'd0, mant_i} << sub_sh;

  // zero for a zero exponent or mantissa, normal when the biased exponent stays at least one, else denormal
  always_comb begin
    if (exp_i == 8'd0 || mant_i == 8'd0) begin
      bits_o = 32'd0;
    end else if (sum >= 9'd10) begin
      bits_o = {1'b0, 8'(sum - 9'd9), norm[22:0]};
    end else begin
      bits_o = subn;
    end
  end

endmodule

FILE: design/rgbe_rle_scanline_decoder_core.sv
// a push goes from S_IDLE to S_EMIT, a run value byte through S_RUN and S_EMIT, a fetch through S_RD, S_CV, S_EMIT
// throughput: one item at a time; runs write one line store byte per cycle,
// fetches read four planes through the single store port and convert the
// three channels through one shared float unit
// reset: asynchronous active low, clears control state; line store is not cleared
module rgbe_rle_scanline_decoder_core import rgbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_item_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [14:0] cfg_data_i
);

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [6:0]  hwh_q, hwh_d;
  logic [1:0]  pi_q, pi_d;
  logic [14:0] pos_q, pos_d;
  logic [7:0]  br_q, br_d;
  logic        ready_q, ready_d;
  logic [14:0] ri_q, ri_d;
  logic [14:0] lf_q, lf_d;
  logic        halt_q, halt_d;
  logic [14:0] lw_q, ih_q;
  logic [7:0]  runval_q, runval_d;
  logic [2:0]  k_q, k_d;
  logic        oor_q, oor_d;
  logic [7:0]  chan_q [4];
  logic [7:0]  chan_d [4];
  out_t        res_q, res_d;
  out_t        out_q, out_d;
  logic        ov_q, ov_d;

  logic                ram_we;
  logic [STORE_AW-1:0] ram_addr;
  logic [7:0]          ram_wdata, ram_rdata;
  logic [FULL_AW-1:0]  wa, ra, wbase, rbase;
  logic [31:0]         flt_bits;
  logic                chk;
  logic [14:0]         npos;
  logic [7:0]          cnt_n;
  logic [14:0]         room;
  logic [7:0]          b;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;
  assign b           = in_item_i.data_byte;

  // plane base addresses
  always_comb begin
    case (pi_q)
      2'd0:    wbase = '0;
      2'd1:    wbase = FULL_AW'(lw_q);
      2'd2:    wbase = FULL_AW'({lw_q, 1'b0});
      default: wbase = FULL_AW'(lw_q) + FULL_AW'({lw_q, 1'b0});
    endcase
    case (k_q[1:0])
      2'd0:    rbase = '0;
      2'd1:    rbase = FULL_AW'(lw_q);
      2'd2:    rbase = FULL_AW'({lw_q, 1'b0});
      default: rbase = FULL_AW'(lw_q) + FULL_AW'({lw_q, 1'b0});
    endcase
  end

  assign wa   = wbase + FULL_AW'(pos_q);
  assign ra   = rbase + FULL_AW'(ri_q);
  assign room = (pos_q < lw_q) ? (lw_q - pos_q) : 15'd0;
  assign cnt_n = (b > 8'd128) ? (b - 8'd128) : b;

  rgbe_ram #(.Width(8), .Depth(STORE_DEPTH)) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // shared float converter, one channel per cycle
  rgbe_flt u_flt (
    .mant_i(chan_q[k_q[1:0]]),
    .exp_i (chan_q[3]),
    .bits_o(flt_bits)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= 15'd8;
      ih_q <= 15'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LINE_WIDTH:   lw_q <= cfg_data_i;
        CFG_IMAGE_HEIGHT: ih_q <= cfg_data_i;
        default:          lw_q <= lw_q;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_HDR0;
      hwh_q   <= '0;
      pi_q    <= '0;
      pos_q   <= '0;
      br_q    <= '0;
      ready_q <= 1'b0;
      ri_q    <= '0;
      lf_q    <= '0;
      halt_q  <= 1'b0;
      k_q     <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      hwh_q   <= hwh_d;
      pi_q    <= pi_d;
      pos_q   <= pos_d;
      br_q    <= br_d;
      ready_q <= ready_d;
      ri_q    <= ri_d;
      lf_q    <= lf_d;
      halt_q  <= halt_d;
      k_q     <= k_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    runval_q <= runval_d;
    oor_q    <= oor_d;
    chan_q   <= chan_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    hwh_d     = hwh_q;
    pi_d      = pi_q;
    pos_d     = pos_q;
    br_d      = br_q;
    ready_d   = ready_q;
    ri_d      = ri_q;
    lf_d      = lf_q;
    halt_d    = halt_q;
    k_d       = k_q;
    runval_d  = runval_q;
    oor_d     = oor_q;
    chan_d    = chan_q;
    res_d     = res_q;
    out_d     = out_q;
    ov_d      = ov_q;
    ram_we    = 1'b0;
    ram_addr  = wa[STORE_AW-1:0];
    ram_wdata = b;
    chk       = 1'b0;
    npos      = pos_q + 15'd1;

    if (ov_q && !out_stall_i) ov_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d        = '0;
          res_d.status = ST_OK;
          state_d      = S_EMIT;
          if (in_item_i.opcode == OP_PUSH) begin
            if (halt_q) begin
              res_d.status = ST_HALTED;
            end else if (ready_q) begin
              res_d.status = ST_PENDING;
            end else begin
              case (phase_q)
                PH_HDR0, PH_HDR1: begin
                  if (b != 8'd2) begin
                    res_d.status = ST_BAD_HEADER;
                    halt_d       = 1'b1;
                  end else begin
                    phase_d = (phase_q == PH_HDR0) ? PH_HDR1 : PH_WHI;
                  end
                end
                PH_WHI: begin
                  if (b[7]) begin
                    res_d.status = ST_BAD_HEADER;
                    halt_d       = 1'b1;
                  end else begin
                    hwh_d   = b[6:0];
                    phase_d = PH_WLO;
                  end
                end
                PH_WLO: begin
                  if (lw_q < 15'd8 || lw_q > 15'(MAX_LINE_WIDTH) || {hwh_q, b} != lw_q) begin
                    res_d.status = ST_WIDTH;
                    halt_d       = 1'b1;
                  end else begin
                    pi_d    = '0;
                    pos_d   = '0;
                    phase_d = PH_COUNT;
                  end
                end
                PH_COUNT: begin
                  if (cnt_n == 8'd0) begin
                    res_d.status = ST_ZERO_COUNT;
                    halt_d       = 1'b1;
                  end else if (15'(cnt_n) > room) begin
                    res_d.status = ST_OVERFLOW;
                    halt_d       = 1'b1;
                  end else begin
                    br_d    = cnt_n;
                    phase_d = (b > 8'd128) ? PH_RUNVAL : PH_LIT;
                  end
                end
                PH_RUNVAL: begin
                  runval_d = b;
                  state_d  = S_RUN;
                end
                PH_LIT: begin
                  ram_we = (wa < FULL_AW'(STORE_DEPTH));
                  pos_d  = npos;
                  br_d   = br_q - 8'd1;
                  if (br_q == 8'd1) phase_d = PH_COUNT;
                  chk = 1'b1;
                end
                default: res_d.status = ST_HALTED;
              endcase
            end
          end else begin
            if (halt_q) begin
              res_d.status = ST_HALTED;
            end else if (!ready_q) begin
              res_d.status = ST_NO_LINE;
            end else begin
              k_d     = '0;
              state_d = S_RD;
            end
          end
        end
      end

      // expand a run one byte per cycle
      S_RUN: begin
        ram_wdata = runval_q;
        ram_we    = (wa < FULL_AW'(STORE_DEPTH));
        pos_d     = npos;
        br_d      = br_q - 8'd1;
        if (br_q <= 8'd1) begin
          br_d    = '0;
          phase_d = PH_COUNT;
          chk     = 1'b1;
          state_d = S_EMIT;
        end
      end

      // read four planes, data lands in the cycle after its address
      S_RD: begin
        ram_addr = ra[STORE_AW-1:0];
        oor_d    = (ra >= FULL_AW'(STORE_DEPTH));
        if (k_q != 3'd0) begin
          chan_d[2'(k_q - 3'd1)] = oor_q ? 8'd0 : ram_rdata;
        end
        k_d = k_q + 3'd1;
        if (k_q == 3'd4) begin
          k_d     = '0;
          state_d = S_CV;
        end
      end

      // convert red, green, blue in turn
      S_CV: begin
        k_d = k_q + 3'd1;
        case (k_q[1:0])
          2'd0:    res_d.red   = flt_bits;
          2'd1:    res_d.green = flt_bits;
          default: res_d.blue  = flt_bits;
        endcase
        if (k_q == 3'd2) begin
          k_d               = '0;
          res_d.pixel_valid = 1'b1;
          res_d.status      = ST_OK;
          state_d           = S_EMIT;
          if (16'(ri_q) + 16'd1 >= 16'(lw_q)) begin
            res_d.last_in_line  = 1'b1;
            res_d.last_in_image = (lf_q >= ih_q);
            ready_d             = 1'b0;
            ri_d                = '0;
          end else begin
            ri_d = ri_q + 15'd1;
          end
        end
      end

      // hand the result to the output register
      S_EMIT: begin
        if (!ov_q || !out_stall_i) begin
          out_d   = res_q;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // plane end and line end
    if (chk && npos >= lw_q) begin
      pos_d = '0;
      if (pi_q != 2'd3) begin
        pi_d = pi_q + 2'd1;
      end else begin
        pi_d                = '0;
        br_d                = '0;
        ready_d             = 1'b1;
        ri_d                = '0;
        lf_d                = lf_q + 15'd1;
        phase_d             = ((lf_q + 15'd1) >= ih_q) ? PH_DONE : PH_HDR0;
        res_d.line_complete = 1'b1;
      end
    end
  end

endmodule

FILE: bench/tb.sv
module tb;
  import rgbe_pkg::*;

  localparam int CYCLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 150;

  logic        clk;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_item;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = CFG_LINE_WIDTH;
  logic [14:0] cfg_data = '0;

  rgbe_rle_scanline_decoder_core uut (
    .clk_i(clk), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  // decoder state mirror
  int unsigned width_reg, height_reg;
  phase_e      phase;
  int unsigned width_hi, plane, plane_pos, bytes_left, read_pos, lines_done;
  bit          line_waiting, halted;
  logic [7:0]  plane_mem [STORE_DEPTH];

  out_t decoded_q[$];
  bit   failed = 1'b0;
  int   items_sent = 0;
  int   idle_cycles = 0;
  bit   send_burst = 1'b0, recv_burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned mem_read(int unsigned addr);
    return addr < STORE_DEPTH ? plane_mem[addr] : 0;
  endfunction

  function automatic void mem_write(int unsigned v);
    int unsigned addr;
    addr = plane * width_reg + plane_pos;
    if (addr < STORE_DEPTH) plane_mem[addr] = v[7:0];
    plane_pos = (plane_pos + 1) & 'h7fff;
  endfunction

  // advance plane or finish the line
  function automatic bit plane_end();
    if (plane_pos < width_reg) return 1'b0;
    plane_pos = 0;
    if (plane < 3) begin
      plane++;
      return 1'b0;
    end
    plane = 0;
    bytes_left = 0;
    line_waiting = 1'b1;
    read_pos = 0;
    lines_done = (lines_done + 1) & 'h7fff;
    phase = (lines_done >= height_reg) ? PH_DONE : PH_HDR0;
    return 1'b1;
  endfunction

  // mantissa times 2^(e-136) as single precision bits
  function automatic logic [31:0] rgbe_float(int unsigned m, int unsigned e);
    int unsigned p;
    int          ex;
    logic [31:0] mb;
    if (e == 0 || m == 0) return '0;
    p = 0;
    while (p < 7 && (m >> (p + 1)) != 0) p++;
    ex = int'(p) + int'(e) - 136;
    mb = m;
    if (ex >= -126) return (32'(ex + 127) << 23) | ((mb << (23 - p)) & 32'h7fffff);
    return mb << (e + 13);
  endfunction

  function automatic logic [2:0] latch_err(logic [2:0] code);
    halted = 1'b1;
    return code;
  endfunction

  function automatic out_t decode_step(in_t it);
    out_t        r;
    int unsigned b, n, i, w, e;
    r = '0;
    b = it.data_byte;
    if (it.opcode == OP_PUSH) begin
      if (halted) r.status = ST_HALTED;
      else if (line_waiting) r.status = ST_PENDING;
      else begin
        r.status = ST_OK;
        case (phase)
          PH_HDR0: begin
            if (b != 2) r.status = latch_err(ST_BAD_HEADER);
            else phase = PH_HDR1;
          end
          PH_HDR1: begin
            if (b != 2) r.status = latch_err(ST_BAD_HEADER);
            else phase = PH_WHI;
          end
          PH_WHI: begin
            if (b[7]) r.status = latch_err(ST_BAD_HEADER);
            else begin
              width_hi = b & 'h7f;
              phase = PH_WLO;
            end
          end
          PH_WLO: begin
            if (width_reg < 8 || width_reg > MAX_LINE_WIDTH ||
                ((width_hi << 8) | b) != width_reg) r.status = latch_err(ST_WIDTH);
            else begin
              plane = 0;
              plane_pos = 0;
              phase = PH_COUNT;
            end
          end
          PH_COUNT: begin
            n = (b > 128) ? b - 128 : b;
            if (n == 0) r.status = latch_err(ST_ZERO_COUNT);
            else if (n > ((plane_pos < width_reg) ? width_reg - plane_pos : 0))
              r.status = latch_err(ST_OVERFLOW);
            else begin
              bytes_left = n;
              phase = (b > 128) ? PH_RUNVAL : PH_LIT;
            end
          end
          PH_RUNVAL: begin
            for (n = bytes_left; n > 0; n--) mem_write(b);
            bytes_left = 0;
            phase = PH_COUNT;
            r.line_complete = plane_end();
          end
          PH_LIT: begin
            mem_write(b);
            bytes_left = (bytes_left - 1) & 'hff;
            if (bytes_left == 0) phase = PH_COUNT;
            r.line_complete = plane_end();
          end
          default: r.status = ST_HALTED;
        endcase
      end
    end else if (halted) r.status = ST_HALTED;
    else if (!line_waiting) r.status = ST_NO_LINE;
    else begin
      i = read_pos;
      w = width_reg;
      e = mem_read(i + 3 * w);
      r.red = rgbe_float(mem_read(i), e);
      r.green = rgbe_float(mem_read(i + w), e);
      r.blue = rgbe_float(mem_read(i + 2 * w), e);
      r.pixel_valid = 1'b1;
      r.status = ST_OK;
      if (i + 1 >= w) begin
        r.last_in_line = 1'b1;
        r.last_in_image = lines_done >= height_reg;
        line_waiting = 1'b0;
        read_pos = 0;
      end else read_pos = (i + 1) & 'h7fff;
    end
    return r;
  endfunction

  // one item onto the input channel
  task automatic send_item(logic op, logic [7:0] b);
    int gap;
    in_t it;
    if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.opcode = op;
    it.data_byte = b;
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    decoded_q.push_back(decode_step(it));
    items_sent++;
  endtask

  task automatic push_byte(int b);
    send_item(OP_PUSH, 8'(b));
  endtask

  task automatic fetch_pixel();
    send_item(OP_FETCH, 8'($urandom_range(0, 255)));
  endtask

  // register write once the decoder has drained
  task automatic write_reg(logic idx, int unsigned value);
    in_valid <= 1'b0;
    while (decoded_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= 15'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LINE_WIDTH) width_reg = value & 'h7fff;
    else height_reg = value & 'h7fff;
  endtask

  // random run and literal coding of one plane
  task automatic code_plane(int unsigned w, int run_pct);
    int unsigned pos, rem, n, k;
    pos = 0;
    while (pos < w) begin
      rem = w - pos;
      if ($urandom_range(0, 9) == 0) fetch_pixel();
      if ($urandom_range(0, 99) < run_pct) begin
        n = $urandom_range(1, rem < 127 ? rem : 127);
        push_byte(128 + n);
        push_byte($urandom_range(0, 255));
      end else begin
        n = $urandom_range(1, rem < 128 ? rem : 128);
        push_byte(n);
        for (k = 0; k < n; k++) push_byte($urandom_range(0, 255));
      end
      pos += n;
    end
  endtask

  task automatic code_line(int unsigned w, int run_pct);
    push_byte(2);
    push_byte(2);
    push_byte(w >> 8);
    push_byte(w & 'hff);
    repeat (4) code_plane(w, run_pct);
  endtask

  task automatic read_line(int unsigned w);
    repeat ($urandom_range(0, 2)) push_byte($urandom_range(0, 255));
    repeat (w) fetch_pixel();
  endtask

  // extremes of bytes, every count kind, pending and empty cases
  task automatic test_directed();
    write_reg(CFG_LINE_WIDTH, 8);
    write_reg(CFG_IMAGE_HEIGHT, 32767);
    fetch_pixel();
    push_byte(2); push_byte(2); push_byte(0); push_byte(8);
    push_byte(8);
    push_byte(8'h00); push_byte(8'hff); push_byte(8'h80); push_byte(8'h7f);
    push_byte(8'h01); push_byte(8'h55); push_byte(8'haa); push_byte(8'hfe);
    push_byte(136); push_byte(8'h80);
    push_byte(1); push_byte(8'hff); push_byte(135); push_byte(8'h01);
    push_byte(128 + 8); push_byte(0);
    push_byte(8); 
    push_byte(0); push_byte(1); push_byte(9); push_byte(136);
    push_byte(255); push_byte(127); push_byte(128); push_byte(2);
    push_byte(8'h33);
    fetch_pixel();
    // image end flag seen by lowering the height to the lines done
    write_reg(CFG_IMAGE_HEIGHT, 1);
    repeat (7) fetch_pixel();
    fetch_pixel();
    write_reg(CFG_IMAGE_HEIGHT, 32767);
  endtask

  // full store width, read back at a narrow width
  task automatic test_widest_line();
    write_reg(CFG_LINE_WIDTH, MAX_LINE_WIDTH);
    code_line(MAX_LINE_WIDTH, 98);
    write_reg(CFG_LINE_WIDTH, 8);
    read_line(8);
  endtask

  task automatic test_random_lines();
    int unsigned w;
    while (items_sent < 1600) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 96) : $urandom_range(8, 40);
      write_reg(CFG_LINE_WIDTH, w);
      code_line(w, $urandom_range(0, 100));
      read_line(w);
    end
  endtask

  // terminal case: image end or one of the latched errors
  task automatic test_terminal();
    int kind;
    kind = $urandom_range(0, 4);
    write_reg(CFG_LINE_WIDTH, 8);
    case (kind)
      0: begin
        write_reg(CFG_IMAGE_HEIGHT, lines_done + 1);
        code_line(8, 50);
        read_line(8);
      end
      1: begin
        push_byte(2);
        if ($urandom_range(0, 1)) push_byte(2);
        push_byte(8'h80 | $urandom_range(0, 127));
      end
      2: begin
        write_reg(CFG_LINE_WIDTH, 32767);
        push_byte(2); push_byte(2); push_byte(8'h7f); push_byte(8'hff);
      end
      3: begin
        push_byte(2); push_byte(2); push_byte(0); push_byte(8);
        push_byte(0);
      end
      default: begin
        push_byte(2); push_byte(2); push_byte(0); push_byte(8);
        push_byte(3); push_byte(1); push_byte(2); push_byte(3);
        push_byte(128 + 6);
      end
    endcase
    repeat (3) push_byte($urandom_range(0, 255));
    repeat (2) fetch_pixel();
    push_byte(2);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  // result checker with random output stall
  initial begin
    int   hold;
    out_t want;
    forever begin
      if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
      hold = recv_burst ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (decoded_q.size() == 0) begin
        $error("result with nothing expected");
        failed = 1'b1;
      end else begin
        want = decoded_q.pop_front();
        check_field("status", want.status, out_item.status);
        check_field("pixel_valid", want.pixel_valid, out_item.pixel_valid);
        check_field("red", want.red, out_item.red);
        check_field("green", want.green, out_item.green);
        check_field("blue", want.blue, out_item.blue);
        check_field("line_complete", want.line_complete, out_item.line_complete);
        check_field("last_in_line", want.last_in_line, out_item.last_in_line);
        check_field("last_in_image", want.last_in_image, out_item.last_in_image);
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    width_reg = 8;
    height_reg = 1;
    phase = PH_HDR0;
    width_hi = 0;
    plane = 0;
    plane_pos = 0;
    bytes_left = 0;
    line_waiting = 1'b0;
    read_pos = 0;
    lines_done = 0;
    halted = 1'b0;
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_directed();
    test_widest_line();
    test_random_lines();
    test_terminal();
    in_valid <= 1'b0;
    while (decoded_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

FILE: rgbe_rle_scanline_decoder_core.f
design/rgbe_pkg.sv
design/rgbe_ram.sv
design/rgbe_flt.sv
design/rgbe_rle_scanline_decoder_core.sv
bench/tb.sv
